[hdl/rnpv_pkg.sv]
// Shared constants, status codes and node layout helpers for the radix node validator.
package rnpv_pkg;

  // Node layout
  localparam int unsigned DenseSlots      = 48;
  localparam int unsigned MaxPayloadBytes = 1048;
  localparam int unsigned PosW            = 11;
  localparam logic [PosW-1:0] PosMax      = 11'd2047;

  // Header and body byte offsets
  localparam logic [PosW-1:0] OffPrefixChk = 11'd19;
  localparam logic [PosW-1:0] OffKind      = 11'd22;
  localparam logic [PosW-1:0] OffFlags     = 11'd23;
  localparam logic [PosW-1:0] OffBody      = 11'd24;
  localparam logic [PosW-1:0] OffK1Child   = 11'd28;
  localparam logic [PosW-1:0] OffK1Pad     = 11'd44;
  localparam logic [PosW-1:0] OffK2Child   = 11'd40;
  localparam logic [PosW-1:0] OffK2Pad     = 11'd104;
  localparam logic [PosW-1:0] OffK3Child   = 11'd280;
  localparam logic [PosW-1:0] OffK3LastIdx = 11'd279;

  // Node kinds
  localparam logic [2:0] KindNone = 3'd0;
  localparam logic [2:0] Kind4    = 3'd1;
  localparam logic [2:0] Kind16   = 3'd2;
  localparam logic [2:0] Kind48   = 3'd3;
  localparam logic [2:0] Kind256  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CfgEmptyChild = 2'd0;
  localparam logic [1:0] CfgEmptyRef   = 2'd1;
  localparam logic [1:0] CfgMaxLocal   = 2'd2;
  localparam logic [1:0] CfgCapacity   = 2'd3;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_LENGTH      = 4'd1,
    ST_KIND        = 4'd2,
    ST_FLAGS       = 4'd3,
    ST_PREFIX      = 4'd4,
    ST_VALUE       = 4'd5,
    ST_COUNT       = 4'd6,
    ST_CHILDREF    = 4'd7,
    ST_UNUSED      = 4'd8,
    ST_ORDER       = 4'd9,
    ST_EMPTYUSED   = 4'd10,
    ST_INDEX       = 4'd11,
    ST_COUNTMISM   = 4'd12,
    ST_TAG         = 4'd13
  } status_t;

  // Total node length per kind
  function automatic logic [PosW-1:0] kind_len(input logic [2:0] k);
    case (k)
      Kind4:   kind_len = 11'd48;
      Kind16:  kind_len = 11'd104;
      Kind48:  kind_len = 11'd472;
      Kind256: kind_len = 11'd1048;
      default: kind_len = 11'd0;
    endcase
  endfunction

  // Child capacity per kind
  function automatic logic [8:0] kind_cap(input logic [2:0] k);
    case (k)
      Kind4:   kind_cap = 9'd4;
      Kind16:  kind_cap = 9'd16;
      Kind48:  kind_cap = 9'd48;
      Kind256: kind_cap = 9'd256;
      default: kind_cap = 9'd0;
    endcase
  endfunction

endpackage

[hdl/radix_node_payload_validator_unit.sv]
// Top level: streaming byte-wise validator for one serialized radix tree node.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one node byte per word, with
//    final_byte marking the last byte and expected_kind sampled on byte 0.
//  - Output channel (out_valid/out_ready) carries one result word per node:
//    first error status, its byte offset and the decoded header fields.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//    empty codes, local id limit and capacity; always ready, write when idle.
//  - Each byte is checked in the cycle it is accepted; one byte per cycle
//    sustained, but for a final byte held back as below. The result word is
//    in the output register in the cycle after the final byte is accepted.
//  - If the receiver stalls, non-final bytes keep flowing; only a final byte
//    waits while the previous result is still held in the output register.
//  - Reset clears the per-node state and the output valid, and loads the
//    register defaults. Per-node state also clears after every final byte.
module radix_node_payload_validator_unit
  import rnpv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  payload_byte,
  input  logic        final_byte,
  input  logic [2:0]  expected_kind,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic [10:0] error_offset,
  output logic [2:0]  node_kind,
  output logic [15:0] child_total,
  output logic        value_present,
  output logic [31:0] prefix_length,
  output logic [63:0] prefix_reference,
  output logic [63:0] value_reference,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Configuration registers
  logic [31:0] empty_child;
  logic [31:0] empty_ref;
  logic [29:0] max_local;
  logic [30:0] capacity;

  // Per-node state
  logic [PosW-1:0] pos, pos_next;
  logic [2:0]  kind, kind_next;
  logic [2:0]  tag, tag_next;
  logic [15:0] count, count_next;
  logic [31:0] plen, plen_next;
  logic [63:0] pref, pref_next;
  logic [63:0] vref, vref_next;
  logic [7:0]  flags, flags_next;
  logic [7:0]  prev_key, prev_key_next;
  logic [DenseSlots-1:0] slot_ref, slot_ref_next;
  logic [8:0]  tally, tally_next;
  logic [31:0] cword, cword_next;
  status_t     err, err_next;
  logic [PosW-1:0] err_at, err_at_next;

  status_t     fcode;
  logic        in_acc;
  logic        out_busy;

  assign cfg_ready = 1'b1;
  assign out_busy  = out_valid && !out_ready;
  assign in_ready  = !(out_busy && final_byte);
  assign in_acc    = in_valid && in_ready;

  function automatic logic ref_bad(input logic [31:0] w, input logic [31:0] eref,
                                   input logic [29:0] mloc, input logic [30:0] cap);
    ref_bad = (w == eref) || (w[29:0] > mloc) || ({1'b0, w[29:0]} >= cap);
  endfunction

  // Per-byte decode and checks
  always_comb begin
    logic [7:0]  b;
    logic [PosW-1:0] p;
    logic [PosW-1:0] off;
    logic [PosW-1:0] cbase;
    logic [PosW-1:0] len_n;
    logic [3:0]  key_idx;
    logic [7:0]  s;
    logic [31:0] w;
    logic        used;
    logic [63:0] slot_wide;
    logic        is_key;
    logic        is_pad;
    b = payload_byte;
    p = pos;
    off = '0;
    cbase = OffBody;
    key_idx = p[3:0] - 4'd8;
    s = '0;
    w = '0;
    used = 1'b0;
    slot_wide = {{(64-DenseSlots){1'b0}}, slot_ref};
    is_key = 1'b0;
    is_pad = 1'b0;
    fcode = ST_OK;
    kind_next = kind;
    tag_next = tag;
    count_next = count;
    plen_next = plen;
    pref_next = pref;
    vref_next = vref;
    flags_next = flags;
    prev_key_next = prev_key;
    slot_ref_next = slot_ref;
    tally_next = tally;
    cword_next = cword;

    if (p == '0) tag_next = expected_kind;

    // Header fields
    if (p < 11'd8) begin
      pref_next[{p[2:0], 3'b000} +: 8] = b;
    end else if (p < 11'd16) begin
      vref_next[{p[2:0], 3'b000} +: 8] = b;
    end else if (p < 11'd20) begin
      plen_next[{p[1:0], 3'b000} +: 8] = b;
      if (p == OffPrefixChk && ((plen_next == '0) != (pref == '0))) fcode = ST_PREFIX;
    end else if (p < OffKind) begin
      count_next[{p[0], 3'b000} +: 8] = b;
    end else if (p == OffKind) begin
      if (b >= 8'd1 && b <= 8'd4) begin
        kind_next = b[2:0];
        if (tag != KindNone && tag != b[2:0]) fcode = ST_TAG;
        if (fcode == ST_OK && b[2:0] != Kind256 &&
            count > {7'd0, kind_cap(b[2:0])}) fcode = ST_COUNT;
      end else begin
        fcode = ST_KIND;
      end
    end else if (p == OffFlags) begin
      flags_next = b;
      if (b[7:1] != '0) fcode = ST_FLAGS;
      if (fcode == ST_OK && !b[0] && vref != '0) fcode = ST_VALUE;
    end else if (kind != KindNone && p < kind_len(kind)) begin
      // Body: key bytes, index bytes, padding and child words
      if (kind == Kind4 || kind == Kind16) begin
        cbase  = (kind == Kind4) ? OffK1Child : OffK2Child;
        is_key = p < (OffBody + {2'b00, kind_cap(kind)});
        is_pad = p >= ((kind == Kind4) ? OffK1Pad : OffK2Pad);
        if (is_key) begin
          if ({12'd0, key_idx} < count) begin
            if (key_idx != '0 && prev_key >= b) fcode = ST_ORDER;
          end else if (b != '0) begin
            fcode = ST_UNUSED;
          end
          prev_key_next = b;
        end else if (is_pad) begin
          if (b != '0) fcode = ST_UNUSED;
        end
      end else if (kind == Kind48) begin
        cbase  = OffK3Child;
        is_key = p < OffK3Child;
        if (is_key) begin
          if (b != 8'hFF) begin
            if ({8'd0, b} >= count || b >= 8'(DenseSlots)) begin
              fcode = ST_INDEX;
            end else if (slot_wide[b[5:0]]) begin
              fcode = ST_INDEX;
            end else begin
              slot_ref_next[b[5:0]] = 1'b1;
              tally_next = tally + 9'd1;
            end
          end
          if (fcode == ST_OK && p == OffK3LastIdx && {7'd0, tally_next} != count)
            fcode = ST_INDEX;
        end
      end else begin
        cbase = OffBody;
      end

      if (!is_key && !is_pad) begin
        off = p - cbase;
        if (off[1:0] == 2'd0) cword_next = {24'd0, b};
        else cword_next[{off[1:0], 3'b000} +: 8] = b;
        w = cword_next;
        s = off[9:2];
        if (off[1:0] == 2'd3) begin
          used = {8'd0, s} < count;
          if (kind == Kind256) begin
            if (w != empty_child) begin
              if (ref_bad(w, empty_ref, max_local, capacity)) fcode = ST_CHILDREF;
              tally_next = tally + 9'd1;
            end
            if (fcode == ST_OK && s == 8'd255 && {7'd0, tally_next} != count)
              fcode = ST_COUNTMISM;
          end else if (used) begin
            if (kind == Kind48 && !slot_wide[s[5:0]]) fcode = ST_INDEX;
            else if (w == empty_child) fcode = ST_EMPTYUSED;
            else if (ref_bad(w, empty_ref, max_local, capacity)) fcode = ST_CHILDREF;
          end else if (w != empty_child) begin
            fcode = ST_UNUSED;
          end
        end
      end
    end

    // Length checks
    len_n = kind_len(kind_next);
    if (fcode == ST_OK && kind_next != KindNone &&
        (p >= len_n || p >= 11'(MaxPayloadBytes))) fcode = ST_LENGTH;
    if (fcode == ST_OK && final_byte &&
        (kind_next == KindNone || ({1'b0, p} + 12'd1) < {1'b0, len_n})) fcode = ST_LENGTH;

    // Keep the first error only
    err_next = err;
    err_at_next = err_at;
    if (err == ST_OK && fcode != ST_OK) begin
      err_next = fcode;
      err_at_next = p;
    end
    pos_next = (p < PosMax) ? p + 11'd1 : PosMax;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      empty_child <= 32'hFFFF_FFFF;
      empty_ref   <= 32'hFFFF_FFFF;
      max_local   <= 30'd1073741822;
      capacity    <= 31'd65536;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgEmptyChild: empty_child <= cfg_data;
        CfgEmptyRef:   empty_ref   <= cfg_data;
        CfgMaxLocal:   max_local   <= cfg_data[29:0];
        CfgCapacity:   capacity    <= cfg_data[30:0];
        default:       ;
      endcase
    end
  end

  // Node state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0; kind <= KindNone; tag <= KindNone; count <= '0;
      plen <= '0; pref <= '0; vref <= '0; flags <= '0; prev_key <= '0;
      slot_ref <= '0; tally <= '0; cword <= '0; err <= ST_OK; err_at <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result wins over the drain of the old one
      if (in_acc && final_byte) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (in_acc) begin
        if (final_byte) begin
          status           <= err_next;
          error_offset     <= err_at_next;
          node_kind        <= kind_next;
          child_total      <= count_next;
          value_present    <= flags_next[0];
          prefix_length    <= plen_next;
          prefix_reference <= pref_next;
          value_reference  <= vref_next;
          pos <= '0; kind <= KindNone; tag <= KindNone; count <= '0;
          plen <= '0; pref <= '0; vref <= '0; flags <= '0; prev_key <= '0;
          slot_ref <= '0; tally <= '0; cword <= '0; err <= ST_OK; err_at <= '0;
        end else begin
          pos <= pos_next; kind <= kind_next; tag <= tag_next; count <= count_next;
          plen <= plen_next; pref <= pref_next; vref <= vref_next;
          flags <= flags_next; prev_key <= prev_key_next; slot_ref <= slot_ref_next;
          tally <= tally_next; cword <= cword_next; err <= err_next; err_at <= err_at_next;
        end
      end
    end
  end

endmodule

[hdl/rnpv_checker.sv]
// Port-level checker for the radix node validator, bound to the top level.
module rnpv_checker
  import rnpv_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  status,
  input logic [10:0] error_offset,
  input logic [2:0]  node_kind
);

  // A held result word stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(error_offset))
    else $error("result word changed while stalled");

  // Reset empties the output register
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A clean node reports offset zero
  a_ok_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> error_offset == '0)
    else $error("clean node with nonzero offset");

  // A bad kind byte leaves no decoded kind
  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_KIND |-> node_kind == KindNone)
    else $error("kind error with decoded kind");

  // A clean node has a valid kind
  a_ok_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> node_kind != KindNone && node_kind <= Kind256)
    else $error("clean node without valid kind");

endmodule

bind radix_node_payload_validator_unit rnpv_checker u_rnpv_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .status(status), .error_offset(error_offset), .node_kind(node_kind)
);

[verif/tb_top.sv]
// Testbench for radix_node_payload_validator_unit: streams nodes, checks each result word.
`timescale 1ns / 1ps

module tb_top;
  import rnpv_pkg::*;

  // Result word of one node
  typedef struct packed {
    status_t     status;
    logic [10:0] error_offset;
    logic [2:0]  node_kind;
    logic [15:0] child_total;
    logic        value_present;
    logic [31:0] prefix_length;
    logic [63:0] prefix_reference;
    logic [63:0] value_reference;
  } node_verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  payload_byte = 8'd0;
  logic        final_byte = 1'b0;
  logic [2:0]  expected_kind = 3'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  status;
  logic [10:0] error_offset;
  logic [2:0]  node_kind;
  logic [15:0] child_total;
  logic        value_present;
  logic [31:0] prefix_length;
  logic [63:0] prefix_reference;
  logic [63:0] value_reference;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data = 32'd0;

  radix_node_payload_validator_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .payload_byte(payload_byte),
    .final_byte(final_byte), .expected_kind(expected_kind),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .error_offset(error_offset), .node_kind(node_kind), .child_total(child_total),
    .value_present(value_present), .prefix_length(prefix_length),
    .prefix_reference(prefix_reference), .value_reference(value_reference),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register shadows
  logic [31:0] sh_empty_child = 32'hFFFF_FFFF;
  logic [31:0] sh_empty_ref   = 32'hFFFF_FFFF;
  logic [29:0] sh_max_local   = 30'd1073741822;
  logic [30:0] sh_capacity    = 31'd65536;

  // Per-node decode state of the predictor
  int          nd_pos;
  logic [2:0]  nd_kind, nd_tag;
  logic [15:0] nd_count;
  logic [31:0] nd_plen;
  logic [63:0] nd_pref, nd_vref;
  logic [7:0]  nd_flags, nd_prev;
  logic [47:0] nd_slots;
  logic [8:0]  nd_tally;
  logic [31:0] nd_word;
  status_t     nd_err;
  logic [10:0] nd_err_at;

  node_verdict_t verdict_q[$];
  logic [7:0]    node_img[$];

  int err_count = 0;
  int mismatch_count = 0;
  int node_count = 0;
  int byte_count = 0;
  int verdict_count = 0;
  int burst_left = 0;
  int hold_left = 0;
  int rx_stall_pct = 0;
  int rx_phase = 0;
  bit hold_req = 1'b0;

  function automatic int span_of(input logic [2:0] k);
    case (k)
      Kind4:   return 48;
      Kind16:  return 104;
      Kind48:  return 472;
      Kind256: return 1048;
      default: return 0;
    endcase
  endfunction

  function automatic int slots_of(input logic [2:0] k);
    case (k)
      Kind4:   return 4;
      Kind16:  return 16;
      Kind48:  return 48;
      Kind256: return 256;
      default: return 0;
    endcase
  endfunction

  task automatic clear_node_state();
    nd_pos = 0; nd_kind = KindNone; nd_tag = 3'd0; nd_count = '0; nd_plen = '0;
    nd_pref = '0; nd_vref = '0; nd_flags = '0; nd_prev = '0; nd_slots = '0;
    nd_tally = '0; nd_word = '0; nd_err = ST_OK; nd_err_at = '0;
  endtask

  // Latch only the first error of the node
  task automatic note_error(input status_t code, input int p);
    if (nd_err == ST_OK) begin
      nd_err = code;
      nd_err_at = p[10:0];
    end
  endtask

  function automatic bit ref_rejected(input logic [31:0] w);
    if (w == sh_empty_ref) return 1'b1;
    if (w[29:0] > sh_max_local) return 1'b1;
    return {1'b0, w[29:0]} >= sh_capacity;
  endfunction

  // A complete child word at slot s
  task automatic judge_child(input int s, input logic [31:0] w, input int p);
    if (nd_kind == Kind256) begin
      if (w != sh_empty_child) begin
        if (ref_rejected(w)) note_error(ST_CHILDREF, p);
        nd_tally = nd_tally + 9'd1;
      end
      if (s == 255 && {7'd0, nd_tally} != nd_count) note_error(ST_COUNTMISM, p);
    end else if (s < nd_count) begin
      if (nd_kind == Kind48 && !nd_slots[s]) note_error(ST_INDEX, p);
      else if (w == sh_empty_child) note_error(ST_EMPTYUSED, p);
      else if (ref_rejected(w)) note_error(ST_CHILDREF, p);
    end else if (w != sh_empty_child) begin
      note_error(ST_UNUSED, p);
    end
  endtask

  task automatic judge_body(input int p, input logic [7:0] b);
    int cbase, cap, off;
    cap = slots_of(nd_kind);
    if (nd_kind == Kind4 || nd_kind == Kind16) begin
      cbase = (nd_kind == Kind4) ? 28 : 40;
      if (p < 24 + cap) begin
        // key bytes: sorted while used, zero when unused
        if (p - 24 < nd_count) begin
          if (p != 24 && nd_prev >= b) note_error(ST_ORDER, p);
        end else if (b != 8'd0) begin
          note_error(ST_UNUSED, p);
        end
        nd_prev = b;
        return;
      end
      if (p >= cbase + 4 * cap) begin
        if (b != 8'd0) note_error(ST_UNUSED, p);
        return;
      end
    end else if (nd_kind == Kind48) begin
      cbase = 280;
      if (p < 280) begin
        // dense index byte
        if (b != 8'hFF) begin
          if (b >= nd_count || b >= 48) note_error(ST_INDEX, p);
          else if (nd_slots[b]) note_error(ST_INDEX, p);
          else begin
            nd_slots[b] = 1'b1;
            nd_tally = nd_tally + 9'd1;
          end
        end
        if (p == 279 && {7'd0, nd_tally} != nd_count) note_error(ST_INDEX, p);
        return;
      end
    end else begin
      cbase = 24;
    end
    off = p - cbase;
    if (off % 4 == 0) nd_word = {24'd0, b};
    else nd_word[8 * (off % 4) +: 8] = b;
    if (off % 4 == 3) judge_child(off / 4, nd_word, p);
  endtask

  // Advance the predictor by one accepted word
  task automatic absorb_byte(input logic [7:0] b, input logic fin, input logic [2:0] ek);
    int p, len;
    node_verdict_t v;
    p = nd_pos;
    if (p == 0) nd_tag = ek;
    if (p < 8) nd_pref[8 * p +: 8] = b;
    else if (p < 16) nd_vref[8 * (p - 8) +: 8] = b;
    else if (p < 20) begin
      nd_plen[8 * (p - 16) +: 8] = b;
      if (p == 19 && ((nd_plen == 0) != (nd_pref == 0))) note_error(ST_PREFIX, p);
    end else if (p < 22) nd_count[8 * (p - 20) +: 8] = b;
    else if (p == 22) begin
      if (b >= 8'd1 && b <= 8'd4) begin
        nd_kind = b[2:0];
        if (nd_tag != 3'd0 && nd_tag != b[2:0]) note_error(ST_TAG, p);
        if (b[2:0] != Kind256 && nd_count > slots_of(b[2:0])) note_error(ST_COUNT, p);
      end else begin
        note_error(ST_KIND, p);
      end
    end else if (p == 23) begin
      nd_flags = b;
      if (b[7:1] != 7'd0) note_error(ST_FLAGS, p);
      if (!b[0] && nd_vref != 0) note_error(ST_VALUE, p);
    end else if (nd_kind != KindNone && p < span_of(nd_kind)) begin
      judge_body(p, b);
    end
    len = span_of(nd_kind);
    if (nd_kind != KindNone && (p >= len || p >= 1048)) note_error(ST_LENGTH, p);
    if (!fin) begin
      nd_pos = (p < 2047) ? p + 1 : 2047;
    end else begin
      if (nd_kind == KindNone || p + 1 < len) note_error(ST_LENGTH, p);
      v.status = nd_err;
      v.error_offset = nd_err_at;
      v.node_kind = nd_kind;
      v.child_total = nd_count;
      v.value_present = nd_flags[0];
      v.prefix_length = nd_plen;
      v.prefix_reference = nd_pref;
      v.value_reference = nd_vref;
      verdict_q.insert(verdict_q.size(), v);
      clear_node_state();
    end
  endtask

  // Receiver: its own stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    rx_phase = rx_phase + 1;
    if (rx_phase % 256 == 0) begin
      case ($urandom_range(0, 4))
        0, 1: rx_stall_pct = 0;
        2: rx_stall_pct = 30;
        3: rx_stall_pct = 60;
        default: rx_stall_pct = 90;
      endcase
    end
    if (hold_req) begin
      hold_left = 3000;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(1, 100) > rx_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    node_verdict_t got, want;
    if (!rst && out_valid && out_ready) begin
      got.status = status_t'(status);
      got.error_offset = error_offset;
      got.node_kind = node_kind;
      got.child_total = child_total;
      got.value_present = value_present;
      got.prefix_length = prefix_length;
      got.prefix_reference = prefix_reference;
      got.value_reference = value_reference;
      verdict_count = verdict_count + 1;
      if (verdict_q.size() == 0) begin
        err_count = err_count + 1;
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
          $display("%0t: result word with nothing expected: status %0d", $realtime, status);
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) begin
          err_count = err_count + 1;
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) begin
            $display("%0t: mismatch exp st=%0d off=%0d kind=%0d cnt=%0d hv=%0d",
                     $realtime, want.status, want.error_offset, want.node_kind,
                     want.child_total, want.value_present);
            $display("    exp plen=%h pref=%h vref=%h", want.prefix_length,
                     want.prefix_reference, want.value_reference);
            $display("%0t:          got st=%0d off=%0d kind=%0d cnt=%0d hv=%0d",
                     $realtime, got.status, got.error_offset, got.node_kind,
                     got.child_total, got.value_present);
            $display("    got plen=%h pref=%h vref=%h", got.prefix_length,
                     got.prefix_reference, got.value_reference);
          end
        end
      end
    end
  end

  // Send one word, with bursts and random gaps
  task automatic send_byte(input logic [7:0] b, input logic fin, input logic [2:0] ek);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 64);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    payload_byte <= b;
    final_byte <= fin;
    expected_kind <= ek;
    do @(posedge clk); while (!(in_valid && in_ready));
    absorb_byte(b, fin, ek);
    burst_left = burst_left - 1;
    byte_count = byte_count + 1;
  endtask

  task automatic send_img(input logic [2:0] ek);
    for (int i = 0; i < node_img.size(); i++)
      send_byte(node_img[i], i == node_img.size() - 1, ek);
    node_count = node_count + 1;
  endtask

  // Cut the node image down to n bytes
  task automatic trim_img(input int n);
    while (node_img.size() > n) node_img.delete(node_img.size() - 1);
  endtask

  // Pause the sender until every expected word has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all four registers back to back while idle
  task automatic program_regs(input logic [31:0] ec, input logic [31:0] er,
                              input logic [31:0] ml, input logic [31:0] nc);
    logic [31:0] vals[4];
    logic [1:0]  idx[4];
    vals = '{ec, er, ml, nc};
    idx = '{CfgEmptyChild, CfgEmptyRef, CfgMaxLocal, CfgCapacity};
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
      case (idx[i])
        CfgEmptyChild: sh_empty_child = vals[i];
        CfgEmptyRef:   sh_empty_ref = vals[i];
        CfgMaxLocal:   sh_max_local = vals[i][29:0];
        default:       sh_capacity = vals[i][30:0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // A child word that the current settings accept, when one exists
  function automatic logic [31:0] live_child();
    longint lim;
    logic [31:0] w;
    lim = {33'd0, sh_capacity};
    if ({34'd0, sh_max_local} + 1 < lim) lim = {34'd0, sh_max_local} + 1;
    w = '0;
    for (int t = 0; t < 8; t++) begin
      w[29:0] = 30'($urandom_range(0, 32'(lim - 1)));
      w[31:30] = 2'($urandom_range(0, 3));
      if (w != sh_empty_ref && w != sh_empty_child) return w;
    end
    return w;
  endfunction

  task automatic push_word(input logic [31:0] w, input int nbytes);
    for (int i = 0; i < nbytes; i++) node_img.insert(node_img.size(), w[8 * i +: 8]);
  endtask

  // Build a canonical node of the given kind into node_img
  task automatic build_node(input logic [2:0] k, input int cnt);
    logic [31:0] kids[256];
    logic [7:0]  dense[256];
    logic [63:0] pref, vref;
    logic        hv;
    int cap, stepmax, key, pos;
    cap = slots_of(k);
    if (cnt > cap) cnt = cap;
    for (int s = 0; s < 256; s++) begin
      kids[s] = sh_empty_child;
      dense[s] = 8'hFF;
    end
    if (k == Kind256) begin
      cnt = 0;
      for (int s = 0; s < 256; s++)
        if ($urandom_range(0, 3) == 0) begin
          kids[s] = live_child();
          cnt++;
        end
    end else begin
      for (int s = 0; s < cnt; s++) kids[s] = live_child();
    end
    pref = ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom(), $urandom()};
    hv = 1'($urandom_range(0, 1));
    vref = hv ? {$urandom(), $urandom()} : 64'd0;
    node_img.delete();
    push_word(pref[31:0], 4);
    push_word(pref[63:32], 4);
    push_word(vref[31:0], 4);
    push_word(vref[63:32], 4);
    push_word((pref == 0) ? 32'd0 : $urandom_range(1, 32'hFFFF_FFFF), 4);
    push_word(cnt, 2);
    node_img.insert(node_img.size(), {5'd0, k});
    node_img.insert(node_img.size(), {7'd0, hv});
    if (k == Kind4 || k == Kind16) begin
      // strictly rising keys, zero past the count
      stepmax = 255 / cap;
      key = $urandom_range(0, stepmax - 1);
      for (int i = 0; i < cap; i++) begin
        node_img.insert(node_img.size(), (i < cnt) ? key[7:0] : 8'd0);
        key = key + $urandom_range(1, stepmax);
      end
    end else if (k == Kind48) begin
      for (int s = 0; s < cnt; s++) begin
        do pos = $urandom_range(0, 255); while (dense[pos] != 8'hFF);
        dense[pos] = s[7:0];
      end
      for (int i = 0; i < 256; i++) node_img.insert(node_img.size(), dense[i]);
    end
    for (int s = 0; s < cap; s++) push_word(kids[s], 4);
    if (k == Kind4) push_word(32'd0, 4);
  endtask

  task automatic mangle_node();
    int i;
    case ($urandom_range(0, 3))
      0: begin
        i = $urandom_range(0, node_img.size() - 1);
        node_img[i] = node_img[i] ^ 8'($urandom_range(1, 255));
      end
      1: begin
        i = $urandom_range(1, node_img.size() - 1);
        trim_img(i);
      end
      2: repeat ($urandom_range(1, 8)) node_img.insert(node_img.size(), 8'($urandom()));
      default: begin
        i = $urandom_range(16, 23);
        node_img[i] = node_img[i] ^ 8'($urandom_range(1, 255));
      end
    endcase
  endtask

  // One random node: mostly canonical, some broken
  task automatic random_node();
    logic [2:0] k, ek;
    int r;
    r = $urandom_range(0, 99);
    k = (r < 50) ? Kind4 : (r < 92) ? Kind16 : (r < 98) ? Kind48 : Kind256;
    build_node(k, $urandom_range(0, slots_of(k)));
    r = $urandom_range(0, 99);
    ek = (r < 60) ? k : (r < 85) ? 3'd0 : 3'($urandom_range(0, 7));
    if ($urandom_range(0, 3) == 0) mangle_node();
    send_img(ek);
  endtask

  // Header field checks and their order of precedence
  task automatic test_header_checks();
    build_node(Kind4, 4);  send_img(Kind4);
    build_node(Kind4, 0);  send_img(3'd0);
    build_node(Kind16, 16); send_img(Kind16);
    build_node(Kind4, 2);
    for (int i = 0; i < 8; i++) node_img[i] = 8'd0;
    node_img[16] = 8'd1;
    send_img(Kind4);
    build_node(Kind4, 1); node_img[8] = 8'h80; node_img[23] = 8'h00; send_img(Kind4);
    build_node(Kind4, 1); node_img[23] = 8'hFE; send_img(Kind4);
    build_node(Kind4, 1); node_img[22] = 8'd0; send_img(3'd0);
    build_node(Kind4, 1); node_img[22] = 8'hFF; node_img[23] = 8'hFF; send_img(Kind4);
    build_node(Kind4, 3); send_img(3'd7);
    build_node(Kind4, 1); node_img[20] = 8'd5; send_img(Kind16);
    build_node(Kind4, 1); node_img[21] = 8'hFF; send_img(Kind4);
    node_img.delete(); node_img.insert(0, 8'hA5); send_img(3'd5);
  endtask

  // Body checks of every kind
  task automatic test_body_checks();
    build_node(Kind16, 3); node_img[25] = node_img[24]; send_img(Kind16);
    build_node(Kind4, 4);
    node_img[24] = 8'd0; node_img[25] = 8'd1; node_img[26] = 8'd2; node_img[27] = 8'hFF;
    send_img(Kind4);
    build_node(Kind4, 2); node_img[27] = 8'd9; send_img(Kind4);
    build_node(Kind4, 1);
    for (int i = 28; i < 32; i++) node_img[i] = 8'hFF;
    send_img(Kind4);
    build_node(Kind4, 1); node_img[31] = 8'h3F; send_img(Kind4);
    build_node(Kind4, 1); node_img[36] = 8'd0; send_img(Kind4);
    build_node(Kind4, 0); node_img[47] = 8'd1; send_img(Kind4);
    // dense kind: whole index area and two child words, then cut short
    build_node(Kind48, 3); trim_img(290); send_img(Kind48);
    build_node(Kind48, 3); node_img[24] = 8'd0; node_img[25] = 8'd0;
    trim_img(30); send_img(Kind48);
    build_node(Kind48, 2); node_img[30] = 8'd47; trim_img(32); send_img(Kind48);
    // full kind: first child above the local id limit
    build_node(Kind256, 0);
    for (int i = 24; i < 27; i++) node_img[i] = 8'hFF;
    node_img[27] = 8'h3F;
    trim_img(40); send_img(Kind256);
  endtask

  // Overlong and short streams
  task automatic test_length();
    build_node(Kind4, 2); repeat (3) node_img.insert(node_img.size(), 8'd0); send_img(Kind4);
    build_node(Kind16, 5);
    trim_img(60);
    send_img(Kind16);
  endtask

  // Register extremes, each with a node, then the defaults again
  task automatic test_register_extremes();
    program_regs(32'd0, 32'd0, 32'd0, 32'd1);
    random_node();
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3FFF_FFFF, 32'h4000_0000);
    random_node();
    program_regs($urandom(), $urandom(), $urandom(), $urandom_range(1, 32'h4000_0000));
    random_node();
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1073741822, 32'd65536);
  endtask

  // Long receiver hold-off while nodes keep coming
  task automatic test_backpressure();
    wait_drained();
    hold_req = 1'b1;
    repeat (3) begin
      build_node(Kind4, $urandom_range(0, 4));
      send_img(Kind4);
    end
    wait_drained();
  endtask

  task automatic test_random();
    int n;
    n = 0;
    while (n < 4) begin
      random_node();
      n++;
      if (n % 2 == 0)
        program_regs($urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom(),
                     $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom(),
                     $urandom(), $urandom_range(1, 32'h4000_0000));
    end
  endtask

  initial begin
    clear_node_state();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_header_checks();
    test_body_checks();
    test_length();
    test_register_extremes();
    test_backpressure();
    test_random();
    wait_drained();
    err_count = err_count + verdict_q.size();
    $display("tb_top: %0d nodes, %0d bytes, %0d result words; all kinds, header/body faults,",
             node_count, byte_count, verdict_count);
    $display("tb_top: register extremes, long output stall and random gaps exercised");
    if (err_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
